@@ hw/rtl/cubemap_face_sample_address_assert.svh @@
// Assertion macros shared by the cube face sample address RTL
`ifndef CUBEMAP_FACE_SAMPLE_ADDRESS_ASSERT_SVH
`define CUBEMAP_FACE_SAMPLE_ADDRESS_ASSERT_SVH

// property that must hold at every clock edge outside reset
`define CFSA_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error(msg);

// cause in one cycle, effect in the next
`define CFSA_ASSERT_NEXT(label, clk, rst, cause, effect, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) \
      else $error(msg);

`endif

@@ hw/rtl/cfsa_pkg.sv @@
// Shared constants, codes and types of the cube face sample address block
`timescale 1ns / 1ps

package cfsa_pkg;

   // field widths
   localparam int COORD_FRAC_BITS   = 16;
   localparam int ADDRESS_BITS      = 24;
   localparam int WEIGHT_BITS       = 16;
   localparam int FACE_BITS         = 3;
   localparam int FRAME_WIDTH_BITS  = 14;
   localparam int FRAME_HEIGHT_BITS = 13;
   localparam int STRIP_BITS        = 13;
   localparam int BLEND_BITS        = 8;
   localparam int CSR_DATA_BITS     = 14;
   localparam int CSR_INDEX_BITS    = 3;

   // datapath widths
   localparam int ROW_BITS    = FRAME_HEIGHT_BITS;
   localparam int OFFSET_BITS = STRIP_BITS;
   localparam int SPAN_BITS   = STRIP_BITS + 1;
   localparam int LPOS_BITS   = SPAN_BITS + COORD_FRAC_BITS + 1;
   localparam int CMP_BITS    = LPOS_BITS + 3;
   localparam int COL_BITS    = STRIP_BITS + 2;
   localparam int NUM_BITS    = WEIGHT_BITS + BLEND_BITS;
   localparam int RW_BITS     = ROW_BITS + FRAME_WIDTH_BITS;

   // weight divider: restoring, DIV_STEP quotient bits per stage
   localparam int DIV_STAGES = 4;
   localparam int DIV_STEP   = WEIGHT_BITS / DIV_STAGES;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = QPTR_BITS + 1;

   // register reset values
   localparam int RESET_FRAME_WIDTH  = 4096;
   localparam int RESET_FRAME_HEIGHT = 1344;
   localparam int RESET_SIDE_WIDTH   = 1376;
   localparam int RESET_CENTER_WIDTH = 1344;
   localparam int RESET_BLEND_WIDTH  = 32;

   typedef enum logic [FACE_BITS-1:0] {
      FACE_LEFT  = 3'd0,
      FACE_RIGHT = 3'd1,
      FACE_FRONT = 3'd2,
      FACE_BACK  = 3'd3,
      FACE_TOP   = 3'd4,
      FACE_DOWN  = 3'd5
   } face_type;

   typedef enum logic [1:0] {
      KIND_NONE,
      KIND_CENTER,
      KIND_SIDE_LOW,
      KIND_SIDE_HIGH
   } kind_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_SIDE_WIDTH   = 3'd2,
      CSR_CENTER_WIDTH = 3'd3,
      CSR_BLEND_WIDTH  = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [FRAME_WIDTH_BITS-1:0]  frame_width;
      logic [FRAME_HEIGHT_BITS-1:0] frame_height;
      logic [STRIP_BITS-1:0]        side_width;
      logic [STRIP_BITS-1:0]        center_width;
      logic [BLEND_BITS-1:0]        blend_width;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      frame_width:  FRAME_WIDTH_BITS'(RESET_FRAME_WIDTH),
      frame_height: FRAME_HEIGHT_BITS'(RESET_FRAME_HEIGHT),
      side_width:   STRIP_BITS'(RESET_SIDE_WIDTH),
      center_width: STRIP_BITS'(RESET_CENTER_WIDTH),
      blend_width:  BLEND_BITS'(RESET_BLEND_WIDTH)
   };

   // classified item, front to back
   typedef struct packed {
      logic                        sel;
      kind_type                    kind;
      logic [ROW_BITS-1:0]         row;
      logic [OFFSET_BITS-1:0]      ctr_off;
      logic signed [LPOS_BITS-1:0] lpos;
   } entry_type;

   // item after column selection
   typedef struct packed {
      logic                valid;
      logic                sel;
      logic                blend;
      logic [ROW_BITS-1:0] row;
      logic [COL_BITS-1:0] col1;
      logic [COL_BITS-1:0] col2;
      logic [NUM_BITS-1:0] n;
   } calc_type;

   // one stage of the address and weight pipeline
   typedef struct packed {
      logic                    valid;
      logic                    sel;
      logic                    blend;
      logic [ROW_BITS-1:0]     row;
      logic [COL_BITS-1:0]     col1;
      logic [COL_BITS-1:0]     col2;
      logic [RW_BITS-1:0]      rw;
      logic [ADDRESS_BITS-1:0] a1;
      logic [ADDRESS_BITS-1:0] a2;
      logic [BLEND_BITS-1:0]   rem;
      logic [WEIGHT_BITS-1:0]  nlo;
      logic [WEIGHT_BITS-1:0]  q;
   } div_stage_type;

endpackage

@@ hw/rtl/cfsa_req_if.sv @@
// Request channel interface: cube face and face coordinate
`timescale 1ns / 1ps

interface cfsa_req_if import cfsa_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [FACE_BITS-1:0]       face_id;
   logic [COORD_FRAC_BITS-1:0] u_coord;
   logic [COORD_FRAC_BITS-1:0] v_coord;

   modport source (output valid, face_id, u_coord, v_coord, input ready);
   modport sink (input valid, face_id, u_coord, v_coord, output ready);
endinterface

@@ hw/rtl/cfsa_rsp_if.sv @@
// Response channel interface: frame select, sample addresses and blend weight
`timescale 1ns / 1ps

interface cfsa_rsp_if import cfsa_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic                    frame_select;
   logic [ADDRESS_BITS-1:0] first_address;
   logic [ADDRESS_BITS-1:0] second_address;
   logic [WEIGHT_BITS-1:0]  blend_weight;
   logic                    blend_needed;

   modport source (output valid, frame_select, first_address, second_address,
                   blend_weight, blend_needed, input ready);
   modport sink (input valid, frame_select, first_address, second_address,
                 blend_weight, blend_needed, output ready);
endinterface

@@ hw/rtl/cfsa_front.sv @@
// Front end: face decode, rotation and the three coordinate products
`timescale 1ns / 1ps

module cfsa_front import cfsa_pkg::*; (
   input  cfg_type          cfg,
   cfsa_req_if.sink         req_chan,
   output logic             push_valid,
   output entry_type        push_entry,
   input  logic             push_ready
);

   logic                                      rotate;
   kind_type                                  kind;
   logic [COORD_FRAC_BITS-1:0]                u_rot;
   logic [COORD_FRAC_BITS-1:0]                v_rot;
   logic [COORD_FRAC_BITS+FRAME_HEIGHT_BITS-1:0] row_prod;
   logic [COORD_FRAC_BITS+STRIP_BITS-1:0]     ctr_prod;
   logic signed [SPAN_BITS-1:0]               span;
   logic signed [LPOS_BITS-1:0]               lpos;

   always_comb begin
      rotate = 1'b0;
      kind   = KIND_NONE;
      unique case (face_type'(req_chan.face_id))
         FACE_LEFT: begin
            kind = KIND_SIDE_LOW;
         end
         FACE_RIGHT: begin
            kind = KIND_SIDE_HIGH;
         end
         FACE_FRONT: begin
            kind = KIND_CENTER;
         end
         FACE_BACK: begin
            kind   = KIND_CENTER;
            rotate = 1'b1;
         end
         FACE_TOP: begin
            kind   = KIND_SIDE_HIGH;
            rotate = 1'b1;
         end
         FACE_DOWN: begin
            kind   = KIND_SIDE_LOW;
            rotate = 1'b1;
         end
         default: begin
            kind   = KIND_NONE;
            rotate = 1'b0;
         end
      endcase
   end

   // quarter turn: u' = v, v' = (1 - lsb) - u
   assign u_rot = rotate ? req_chan.v_coord : req_chan.u_coord;
   assign v_rot = rotate ? ~req_chan.u_coord : req_chan.v_coord;

   assign row_prod = v_rot * cfg.frame_height;
   assign ctr_prod = u_rot * cfg.center_width;

   // side strip span S - 2B can go negative
   assign span = $signed({1'b0, cfg.side_width})
               - $signed({{(SPAN_BITS-BLEND_BITS-1){1'b0}}, cfg.blend_width, 1'b0});
   assign lpos = span * $signed({1'b0, u_rot});

   assign push_valid         = req_chan.valid;
   assign req_chan.ready     = push_ready;
   assign push_entry.sel     = rotate;
   assign push_entry.kind    = kind;
   assign push_entry.row     = row_prod[COORD_FRAC_BITS+ROW_BITS-1:COORD_FRAC_BITS];
   assign push_entry.ctr_off = ctr_prod[COORD_FRAC_BITS+OFFSET_BITS-1:COORD_FRAC_BITS];
   assign push_entry.lpos    = lpos;

endmodule

@@ hw/rtl/cfsa_queue.sv @@
// Small register queue between front and back
`timescale 1ns / 1ps
`include "cubemap_face_sample_address_assert.svh"

module cfsa_queue import cfsa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  logic      push_valid,
   input  entry_type push_entry,
   output logic      push_ready,
   output logic      pop_valid,
   output entry_type pop_entry,
   input  logic      pop_ready
);

   entry_type              slot_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff;
   logic [QPTR_BITS-1:0]   wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff;
   logic [QPTR_BITS-1:0]   rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff;
   logic [QCOUNT_BITS-1:0] count_in;
   logic                   push;
   logic                   pop;

   assign push_ready = (count_ff != QCOUNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_entry  = slot_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

   `CFSA_ASSERT_NEXT(a_count_up, clock, reset, push && !pop, count_ff == $past(count_ff) + 1'b1, "queue count did not grow on push")
   `CFSA_ASSERT_NEXT(a_count_down, clock, reset, pop && !push, count_ff == $past(count_ff) - 1'b1, "queue count did not shrink on pop")
   `CFSA_ASSERT(a_ptr_gap, clock, reset, QPTR_BITS'(wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_BITS-1:0], "queue pointers disagree with count")

endmodule

@@ hw/rtl/cfsa_back.sv @@
// Back end: column selection, address multiply-add and pipelined weight divider
`timescale 1ns / 1ps
`include "cubemap_face_sample_address_assert.svh"

module cfsa_back import cfsa_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   input  cfg_type   cfg,
   input  logic      pop_valid,
   input  entry_type pop_entry,
   output logic      pop_ready,
   cfsa_rsp_if.source rsp_chan
);

   // strip column from a position scaled by 2^F, clamped to [0, S-1]
   function automatic logic [STRIP_BITS-1:0] strip_col(
      input logic signed [CMP_BITS-1:0] pos,
      input logic [STRIP_BITS-1:0]      width
   );
      logic [STRIP_BITS-1:0]               lim;
      logic [CMP_BITS-COORD_FRAC_BITS-1:0] whole;
      lim   = (width == '0) ? '0 : width - 1'b1;
      whole = pos[CMP_BITS-1:COORD_FRAC_BITS];
      if (pos[CMP_BITS-1]) begin
         strip_col = '0;
      end else if (whole > (CMP_BITS-COORD_FRAC_BITS)'(lim)) begin
         strip_col = lim;
      end else begin
         strip_col = whole[STRIP_BITS-1:0];
      end
   endfunction

   logic                       adv;
   calc_type                   calc_ff;
   calc_type                   calc_in;
   div_stage_type              st_ff  [DIV_STAGES];
   div_stage_type              st_in  [DIV_STAGES];
   div_stage_type              st_src [DIV_STAGES];
   div_stage_type              cur;
   div_stage_type              out_stage;
   logic [BLEND_BITS:0]        trial;

   logic signed [CMP_BITS-1:0]  lp;
   logic signed [CMP_BITS-1:0]  lp2;
   logic signed [CMP_BITS-1:0]  rp;
   logic signed [CMP_BITS-1:0]  thr_lo;
   logic signed [CMP_BITS-1:0]  thr_hi;
   logic signed [CMP_BITS-1:0]  num;
   logic signed [SPAN_BITS-1:0] span4;
   logic [COL_BITS-1:0]         x0;
   logic [COL_BITS-1:0]         col_l;
   logic [COL_BITS-1:0]         col_r;
   logic [COL_BITS-1:0]         col_c;

   assign out_stage = st_ff[DIV_STAGES-1];
   // whole back end moves together unless a result sits untaken
   assign adv       = !out_stage.valid || rsp_chan.ready;
   assign pop_ready = adv;

   // seam geometry
   always_comb begin
      lp     = {{(CMP_BITS-LPOS_BITS){pop_entry.lpos[LPOS_BITS-1]}}, pop_entry.lpos};
      lp2    = lp <<< 1;
      span4  = $signed({1'b0, cfg.side_width})
             - $signed({{(SPAN_BITS-BLEND_BITS-2){1'b0}}, cfg.blend_width, 2'b00});
      thr_lo = {{(CMP_BITS-SPAN_BITS-COORD_FRAC_BITS){span4[SPAN_BITS-1]}}, span4,
                {COORD_FRAC_BITS{1'b0}}};
      thr_hi = {{(CMP_BITS-STRIP_BITS-COORD_FRAC_BITS){1'b0}}, cfg.side_width,
                {COORD_FRAC_BITS{1'b0}}};
      rp     = lp + $signed({{(CMP_BITS-BLEND_BITS-COORD_FRAC_BITS-1){1'b0}},
                             cfg.blend_width, {(COORD_FRAC_BITS+1){1'b0}}});
      num    = lp2 - thr_lo;
      x0     = (pop_entry.kind == KIND_SIDE_HIGH)
             ? COL_BITS'(cfg.side_width) + COL_BITS'(cfg.center_width) : '0;
      col_l  = x0 + COL_BITS'(strip_col(lp, cfg.side_width));
      col_r  = x0 + COL_BITS'(strip_col(rp, cfg.side_width));
      col_c  = COL_BITS'(cfg.side_width) + COL_BITS'(pop_entry.ctr_off);
   end

   always_comb begin
      calc_in.valid = pop_valid;
      calc_in.sel   = pop_entry.sel;
      calc_in.blend = 1'b0;
      calc_in.row   = pop_entry.row;
      calc_in.col1  = '0;
      calc_in.col2  = '0;
      calc_in.n     = num[NUM_BITS+1:2];
      unique case (pop_entry.kind)
         KIND_NONE: begin
            calc_in.row = '0;
         end
         KIND_CENTER: begin
            calc_in.col1 = col_c;
            calc_in.col2 = col_c;
         end
         KIND_SIDE_LOW, KIND_SIDE_HIGH: begin
            priority if (lp2 <= thr_lo) begin
               calc_in.col1 = col_l;
               calc_in.col2 = col_l;
            end else if (lp2 >= thr_hi) begin
               calc_in.col1 = col_r;
               calc_in.col2 = col_r;
            end else begin
               calc_in.col1  = col_l;
               calc_in.col2  = col_r;
               calc_in.blend = 1'b1;
            end
         end
      endcase
   end

   // weight = floor(n / B); stage 0 also forms row*W, stage 1 the two sums
   always_comb begin
      st_src[0].valid = calc_ff.valid;
      st_src[0].sel   = calc_ff.sel;
      st_src[0].blend = calc_ff.blend;
      st_src[0].row   = calc_ff.row;
      st_src[0].col1  = calc_ff.col1;
      st_src[0].col2  = calc_ff.col2;
      st_src[0].rw    = '0;
      st_src[0].a1    = '0;
      st_src[0].a2    = '0;
      st_src[0].rem   = calc_ff.n[NUM_BITS-1:WEIGHT_BITS];
      st_src[0].nlo   = calc_ff.n[WEIGHT_BITS-1:0];
      st_src[0].q     = '0;
      for (int i = 1; i < DIV_STAGES; i++) begin
         st_src[i] = st_ff[i-1];
      end
      cur   = st_src[0];
      trial = '0;
      for (int i = 0; i < DIV_STAGES; i++) begin
         cur = st_src[i];
         for (int k = 0; k < DIV_STEP; k++) begin
            trial   = {cur.rem, cur.nlo[WEIGHT_BITS-1]};
            cur.nlo = {cur.nlo[WEIGHT_BITS-2:0], 1'b0};
            if (trial >= {1'b0, cfg.blend_width}) begin
               cur.rem = BLEND_BITS'(trial - {1'b0, cfg.blend_width});
               cur.q   = {cur.q[WEIGHT_BITS-2:0], 1'b1};
            end else begin
               cur.rem = trial[BLEND_BITS-1:0];
               cur.q   = {cur.q[WEIGHT_BITS-2:0], 1'b0};
            end
         end
         if (i == 0) begin
            cur.rw = cur.row * cfg.frame_width;
         end
         if (i == 1) begin
            cur.a1 = cur.rw[ADDRESS_BITS-1:0] + ADDRESS_BITS'(cur.col1);
            cur.a2 = cur.rw[ADDRESS_BITS-1:0] + ADDRESS_BITS'(cur.col2);
         end
         st_in[i] = cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         calc_ff.valid <= 1'b0;
         for (int i = 0; i < DIV_STAGES; i++) begin
            st_ff[i].valid <= 1'b0;
         end
      end else if (adv) begin
         calc_ff <= calc_in;
         for (int i = 0; i < DIV_STAGES; i++) begin
            st_ff[i] <= st_in[i];
         end
      end
   end

   assign rsp_chan.valid          = out_stage.valid;
   assign rsp_chan.frame_select   = out_stage.sel;
   assign rsp_chan.first_address  = out_stage.a1;
   assign rsp_chan.second_address = out_stage.a2;
   assign rsp_chan.blend_weight   = out_stage.blend ? out_stage.q : '0;
   assign rsp_chan.blend_needed   = out_stage.blend;

   `CFSA_ASSERT(a_single_sample, clock, reset, (rsp_chan.valid && !rsp_chan.blend_needed) |-> (rsp_chan.second_address == rsp_chan.first_address), "single sample with two addresses")
   `CFSA_ASSERT(a_blend_zone, clock, reset, (rsp_chan.valid && rsp_chan.blend_needed) |-> (cfg.blend_width != '0), "blend beat with zero blend width")
   `CFSA_ASSERT_NEXT(a_stall_freeze, clock, reset, rsp_chan.valid && !rsp_chan.ready, $stable(calc_ff) && $stable(st_ff[0]), "back end moved during stall")

endmodule

@@ hw/rtl/cubemap_face_sample_address.sv @@
// Top level: configuration registers, front end, queue and back end
`timescale 1ns / 1ps

// Cube face sample address generator.
// req_chan carries one beat per sample: face_id (0 left, 1 right, 2 front,
// 3 back, 4 top, 5 down) and a face coordinate u_coord, v_coord in 1/65536.
// rsp_chan returns one beat per request, in order: frame_select, the first
// and second pixel addresses (row*frame_width+column, 24-bit wrap), the blend
// weight of the second sample and blend_needed.
// The csr_ port writes the five geometry registers (index 0 frame_width,
// 1 frame_height, 2 side_width, 3 center_width, 4 blend_width); write them
// only while no beat is in flight.
// Throughput is one beat per cycle while rsp_chan takes every response.
// From request acceptance a beat passes through the four-entry queue, the
// column selection register and then the four-stage weight divider, which
// also holds the row*frame_width multiply and the address adds.
// Reset empties the queue and pipeline and loads the default geometry.
// When rsp_chan stalls the back end freezes and the queue keeps taking
// requests until its four entries are full.
module cubemap_face_sample_address import cfsa_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   cfsa_req_if.sink                  req_chan,
   cfsa_rsp_if.source                rsp_chan,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_write_data
);

   cfg_type   cfg_ff;
   cfg_type   cfg_in;
   logic      push_valid;
   logic      push_ready;
   entry_type push_entry;
   logic      pop_valid;
   logic      pop_ready;
   entry_type pop_entry;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_FRAME_WIDTH:  cfg_in.frame_width  = csr_write_data[FRAME_WIDTH_BITS-1:0];
            CSR_FRAME_HEIGHT: cfg_in.frame_height = csr_write_data[FRAME_HEIGHT_BITS-1:0];
            CSR_SIDE_WIDTH:   cfg_in.side_width   = csr_write_data[STRIP_BITS-1:0];
            CSR_CENTER_WIDTH: cfg_in.center_width = csr_write_data[STRIP_BITS-1:0];
            CSR_BLEND_WIDTH:  cfg_in.blend_width  = csr_write_data[BLEND_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= CFG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   cfsa_front u_front (
      .cfg        (cfg_ff),
      .req_chan   (req_chan),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready)
   );

   cfsa_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_entry (push_entry),
      .push_ready (push_ready),
      .pop_valid  (pop_valid),
      .pop_entry  (pop_entry),
      .pop_ready  (pop_ready)
   );

   cfsa_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .pop_valid (pop_valid),
      .pop_entry (pop_entry),
      .pop_ready (pop_ready),
      .rsp_chan  (rsp_chan)
   );

endmodule
